/* src/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by a consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* src/tcp_opt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcp_opt_pkg;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY,
        PH_STOP_OK,
        PH_STOP_FAIL
    } t_phase;

    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_SACKP  = 8'd4;
    localparam logic [7:0] KIND_SACK   = 8'd5;
    localparam logic [7:0] KIND_TS     = 8'd8;

    localparam logic [7:0] MIN_LEN_MSS    = 8'd4;
    localparam logic [7:0] MIN_LEN_WSCALE = 8'd3;
    localparam logic [7:0] MIN_LEN_TS     = 8'd10;
    localparam logic [7:0] MIN_LEN_OTHER  = 8'd2;
    localparam logic [7:0] LEN_HEADER     = 8'd2;

    localparam int SEEN_MSS   = 0;
    localparam int SEEN_WS    = 1;
    localparam int SEEN_SACKP = 2;
    localparam int SEEN_TS    = 3;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic        mss_seen;
        logic [15:0] mss_value;
        logic        wscale_seen;
        logic [7:0]  wscale_value;
        logic        sack_permitted_seen;
        logic        timestamp_seen;
        logic [31:0] timestamp_value;
        logic [31:0] timestamp_echo;
    } t_out_item;

    function automatic logic kind_known(input logic [7:0] kind);
        return (kind == KIND_MSS) || (kind == KIND_WSCALE) || (kind == KIND_SACKP) ||
               (kind == KIND_SACK) || (kind == KIND_TS);
    endfunction

    function automatic logic [7:0] kind_minimum(input logic [7:0] kind);
        logic [7:0] min_len;
        case (kind)
            KIND_MSS:    min_len = MIN_LEN_MSS;
            KIND_WSCALE: min_len = MIN_LEN_WSCALE;
            KIND_TS:     min_len = MIN_LEN_TS;
            default:     min_len = MIN_LEN_OTHER;
        endcase
        return min_len;
    endfunction

endpackage

`default_nettype wire

/* src/tcp_option_parser_core.sv */
// TCP option parser. The block takes the option area of one segment one byte per
// transfer, in wire order, with last_byte set on the final byte, and accepts a byte
// in every cycle while the skid entry is empty. Each byte updates a small parse
// state. The transfer that carries the final byte produces one result on the next
// clock edge, in the output register or, while that register still waits
// downstream, in the skid entry; then the parser is back in its reset state for the
// next option area. Input keeps flowing while one result waits downstream; input
// stalls only when both the output register and the skid entry are full.
`timescale 1ns / 1ps
`default_nettype none

module tcp_option_parser_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire tcp_opt_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output tcp_opt_pkg::t_out_item o_out_data
);
    import tcp_opt_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_left, n_left;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_pending, n_pending;
    logic [15:0] r_mss, n_mss;
    logic [7:0]  r_wscale, n_wscale;
    logic [63:0] r_stamp, n_stamp;
    logic [3:0]  r_seen, n_seen;
    logic        s_commit;
    t_out_item   s_result;

    logic        r_out_valid;
    t_out_item   r_out_data;
    logic        r_skid_valid;
    t_out_item   r_skid_data;

    logic        s_in_fire;
    logic        s_out_fire;
    logic        s_new_result;

    assign o_in_ready   = !r_skid_valid;
    assign s_in_fire    = i_in_valid && o_in_ready;
    assign s_out_fire   = r_out_valid && i_out_ready;
    assign s_new_result = s_in_fire && i_in_data.last_byte;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_left    = r_left;
        n_pos     = r_pos;
        n_pending = r_pending;
        s_commit  = 1'b0;
        case (r_phase)
            PH_KIND: begin
                if (i_in_data.option_byte == KIND_EOL) begin
                    n_phase = PH_STOP_OK;
                end else if (i_in_data.option_byte != KIND_NOP) begin
                    n_kind  = i_in_data.option_byte;
                    n_phase = i_in_data.last_byte ? PH_STOP_FAIL : PH_LEN;
                end
            end
            PH_LEN: begin
                if (!kind_known(r_kind)) begin
                    n_phase = PH_STOP_OK;
                end else if (i_in_data.option_byte < kind_minimum(r_kind)) begin
                    n_phase = PH_STOP_FAIL;
                end else begin
                    n_pending = '0;
                    n_pos     = '0;
                    n_left    = i_in_data.option_byte - LEN_HEADER;
                    if (n_left == 8'd0) begin
                        s_commit = 1'b1;
                        n_phase  = PH_KIND;
                    end else begin
                        n_phase = i_in_data.last_byte ? PH_STOP_FAIL : PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (!r_pos[3]) begin
                    for (int i = 0; i < 8; i++) begin
                        if (r_pos[2:0] == 3'(i)) begin
                            n_pending[8 * (7 - i) +: 8] = i_in_data.option_byte;
                        end
                    end
                    n_pos = r_pos + 4'd1;
                end
                n_left = r_left - 8'd1;
                if (n_left == 8'd0) begin
                    s_commit = 1'b1;
                    n_phase  = PH_KIND;
                end else if (i_in_data.last_byte) begin
                    n_phase = PH_STOP_FAIL;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_mss    = r_mss;
        n_wscale = r_wscale;
        n_stamp  = r_stamp;
        n_seen   = r_seen;
        if (s_commit) begin
            case (r_kind)
                KIND_MSS: begin
                    n_mss            = n_pending[63:48];
                    n_seen[SEEN_MSS] = 1'b1;
                end
                KIND_WSCALE: begin
                    n_wscale        = n_pending[63:56];
                    n_seen[SEEN_WS] = 1'b1;
                end
                KIND_SACKP: begin
                    n_seen[SEEN_SACKP] = 1'b1;
                end
                KIND_TS: begin
                    n_stamp         = n_pending;
                    n_seen[SEEN_TS] = 1'b1;
                end
                default: begin
                end
            endcase
        end
        s_result.ok                  = (n_phase != PH_STOP_FAIL);
        s_result.mss_seen            = n_seen[SEEN_MSS];
        s_result.mss_value           = n_seen[SEEN_MSS] ? n_mss : 16'd0;
        s_result.wscale_seen         = n_seen[SEEN_WS];
        s_result.wscale_value        = n_seen[SEEN_WS] ? n_wscale : 8'd0;
        s_result.sack_permitted_seen = n_seen[SEEN_SACKP];
        s_result.timestamp_seen      = n_seen[SEEN_TS];
        s_result.timestamp_value     = n_seen[SEEN_TS] ? n_stamp[63:32] : 32'd0;
        s_result.timestamp_echo      = n_seen[SEEN_TS] ? n_stamp[31:0] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KIND;
            r_seen  <= '0;
        end else if (s_in_fire) begin
            if (i_in_data.last_byte) begin
                r_phase <= PH_KIND;
                r_seen  <= '0;
            end else begin
                r_phase <= n_phase;
                r_seen  <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_fire) begin
            r_kind    <= n_kind;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_pending <= n_pending;
            r_mss     <= n_mss;
            r_wscale  <= n_wscale;
            r_stamp   <= n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (s_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (s_new_result) begin
            if (!r_out_valid || s_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (s_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (s_out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (s_new_result) begin
            if (!r_out_valid || s_out_fire) begin
                r_out_data <= s_result;
            end else begin
                r_skid_data <= s_result;
            end
        end
    end

endmodule

`default_nettype wire

/* src/tcp_opt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcp_opt_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_valid,
    input wire                    o_in_ready,
    input wire tcp_opt_pkg::t_in_item  i_in_data,
    input wire                    o_out_valid,
    input wire                    i_out_ready,
    input wire tcp_opt_pkg::t_out_item o_out_data
);
    import tcp_opt_pkg::*;

    logic s_in_seen;

    assign s_in_seen = i_in_valid && i_in_data.last_byte;

    // A stalled result stays offered and unchanged until its transfer.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data), "result changed while stalled")
    // Input is held back only while a result is waiting downstream.
    `ASSERT_ALWAYS(a_ready_space, i_clk, i_rst_n, o_in_ready || o_out_valid, "input stalled with empty output")
    // Value fields of options that were not seen read as zero.
    `ASSERT_ALWAYS(a_mss_gate, i_clk, i_rst_n, !o_out_valid || o_out_data.mss_seen || (o_out_data.mss_value == 16'd0), "MSS value without MSS option")
    `ASSERT_ALWAYS(a_ts_gate, i_clk, i_rst_n, !o_out_valid || o_out_data.timestamp_seen || ((o_out_data.timestamp_value == 32'd0) && (o_out_data.timestamp_echo == 32'd0)) || s_in_seen, "timestamp value without timestamp option")

endmodule

bind tcp_option_parser_core tcp_opt_checker u_tcp_opt_checker (.*);

`default_nettype wire
